>>> rtl/tpts_pkg.sv
// Package for the tick-driven priority task scheduler.
// Holds the item codes, task state codes and the task entry type.
// No dependencies.
`timescale 1ns / 1ps

package tpts_pkg;

	// item kinds, carried on s_tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// task states
	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_READY    = 2'd1;
	localparam logic [1:0] ST_DELAYED  = 2'd2;
	localparam logic [1:0] ST_WAITING  = 2'd3;

	typedef struct packed {
		logic [1:0]  state;
		logic [31:0] delay;
		logic [7:0]  prio;
	} task_entry_t;

endpackage

>>> rtl/tpts_table.sv
// Task entry table: one flop row per task, one read and one write port.
// Depends on tpts_pkg.
`timescale 1ns / 1ps

module tpts_table import tpts_pkg::*; #(
	parameter int NUM_TASKS = 8,
	parameter int IW = $clog2(NUM_TASKS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_addr,
	output task_entry_t   rd_entry,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  task_entry_t   wr_entry
);

	task_entry_t entry_q [NUM_TASKS];

	// reset value of every entry: inactive, zero delay, zero priority
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr_en) begin
			entry_q[wr_addr] <= wr_entry;
		end
	end

	// addresses at or above the depth only occur for non-power-of-two depths
	assign rd_entry = (32'(rd_addr) < 32'(NUM_TASKS)) ? entry_q[rd_addr] : '0;

endmodule

>>> rtl/tick_priority_task_scheduler.sv
// Top level of the tick-driven priority task scheduler.
// Depends on tpts_pkg and tpts_table.
`timescale 1ns / 1ps

// Tick-driven priority task scheduler. Each input beat is a write of one task
// entry (state, delay, priority), a start that makes a task current, or a
// tick; each beat yields exactly one output beat with the current task and a
// flag that is set when the current task changed. Write and start beats (and
// the unused kind) finish in the accept cycle; their result shows on the next
// cycle. A tick walks the ring of tasks one entry per cycle with a single
// shared decrement/compare unit: a prep state fetches the initial candidate,
// a walk state visits each task of the ring, and a final state posts the
// result once the output register is free. The ring size is task_count,
// where 0 acts as 1 and values above NUM_TASKS act as NUM_TASKS. s_tready
// is low during a tick walk and while an unread result sits in the output
// register. task_count may only be written while the block is idle.
module tick_priority_task_scheduler import tpts_pkg::*; #(
	parameter int NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        task_count_we,
	input  logic [3:0]  task_count_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: task_index[2:0], new_state[4:3], delay_ticks[36:5],
	//          task_priority_in[44:37], semaphore_free_mask[52:45], zero[55:53]
	input  logic [55:0] s_tdata,
	// s_tuser: operation[1:0]
	input  logic [1:0]  s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: current_task[2:0], switched[3], zero[7:4]
	output logic [7:0]  m_tdata
);

	localparam int IW = $clog2(NUM_TASKS);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;  // fetch initial candidate
	localparam logic [1:0] S_WALK = 2'd2;  // one task per cycle
	localparam logic [1:0] S_FIN  = 2'd3;  // post result

	// input fields
	logic [1:0]  operation;
	logic [2:0]  task_index;
	logic [1:0]  new_state;
	logic [31:0] delay_ticks;
	logic [7:0]  task_priority_in;
	logic [7:0]  semaphore_free_mask;

	assign operation           = s_tuser;
	assign task_index          = s_tdata[2:0];
	assign new_state           = s_tdata[4:3];
	assign delay_ticks         = s_tdata[36:5];
	assign task_priority_in    = s_tdata[44:37];
	assign semaphore_free_mask = s_tdata[52:45];

	logic [1:0]    state_q;
	logic [3:0]    task_count_q;
	logic [IW-1:0] running_q;
	logic [IW-1:0] last_q;     // ring size minus one, latched at tick
	logic [IW-1:0] t_q;        // task being visited
	logic [IW-1:0] left_q;     // visits remaining after this one
	logic [IW-1:0] cand_q;
	logic          cand_ready_q;
	logic [7:0]    cand_prio_q;
	logic [7:0]    mask_q;
	logic          m_tvalid_q;
	logic [2:0]    out_task_q;
	logic          out_sw_q;

	// table ports
	logic [IW-1:0] rd_addr;
	task_entry_t   rd_entry;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	task_entry_t   wr_entry;

	tpts_table #(
		.NUM_TASKS (NUM_TASKS),
		.IW        (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	// handshake
	logic slot_free;
	logic in_acc;
	logic post_res;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && slot_free;
	assign in_acc    = s_tvalid && s_tready;
	// a result beat is loaded by a single-cycle beat or at the end of a walk
	assign post_res  = (in_acc && operation != OP_TICK) || (state_q == S_FIN && slot_free);

	// ring bounds from the current register value
	logic [IW-1:0] ring_last;
	logic [IW-1:0] walk_start;
	logic [IW-1:0] start_next;

	always_comb begin
		if (task_count_q == 4'd0) begin
			ring_last = '0;
		end else if (32'(task_count_q) > 32'(NUM_TASKS)) begin
			ring_last = IW'(NUM_TASKS - 1);
		end else begin
			ring_last = IW'(task_count_q - 4'd1);
		end
	end

	// a current task outside the ring starts the walk at task 0
	assign walk_start = (running_q <= ring_last) ? running_q : '0;
	assign start_next = (walk_start == ring_last) ? '0 : walk_start + IW'(1);

	// shared walk unit: count down, free test, priority compare
	logic [31:0] free_sh;
	logic        free_bit;
	logic [31:0] dec_delay;
	logic        made_ready;
	logic [1:0]  visit_state;
	logic        take_cand;
	logic [IW-1:0] t_next;

	assign free_sh   = 32'(mask_q) >> t_q;
	assign free_bit  = free_sh[0];
	assign dec_delay = (rd_entry.delay != 32'd0) ? rd_entry.delay - 32'd1 : 32'd0;
	assign t_next    = (t_q == last_q) ? '0 : t_q + IW'(1);

	always_comb begin
		visit_state = rd_entry.state;
		made_ready  = 1'b0;
		take_cand   = 1'b0;
		unique case (rd_entry.state)
			ST_DELAYED: begin
				made_ready = (dec_delay == 32'd0);
			end
			ST_WAITING: begin
				made_ready = free_bit || (dec_delay == 32'd0);
			end
			ST_READY: begin
				take_cand = !cand_ready_q || (rd_entry.prio >= cand_prio_q);
			end
			ST_INACTIVE: begin
			end
		endcase
		if (made_ready) begin
			visit_state = ST_READY;
		end
	end

	// table access
	logic is_delay_state;

	assign is_delay_state = (rd_entry.state == ST_DELAYED) || (rd_entry.state == ST_WAITING);

	always_comb begin
		rd_addr  = (state_q == S_PREP) ? cand_q : t_q;
		wr_en    = 1'b0;
		wr_addr  = t_q;
		wr_entry = '{state: visit_state, delay: dec_delay, prio: rd_entry.prio};
		if (in_acc && operation == OP_WRITE && 32'(task_index) < 32'(NUM_TASKS)) begin
			wr_en    = 1'b1;
			wr_addr  = IW'(task_index);
			wr_entry = '{state: new_state, delay: delay_ticks, prio: task_priority_in};
		end else if (state_q == S_WALK && is_delay_state) begin
			wr_en = 1'b1;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= 4'd1;
		end else if (task_count_we) begin
			task_count_q <= task_count_wdata;
		end
	end

	// output valid: set when a result is posted, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (post_res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			running_q    <= '0;
			last_q       <= '0;
			t_q          <= '0;
			left_q       <= '0;
			cand_q       <= '0;
			cand_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						priority if (operation == OP_TICK) begin
							state_q <= S_PREP;
							last_q  <= ring_last;
							t_q     <= walk_start;
							left_q  <= ring_last;
							cand_q  <= start_next;
						end else begin
							if (operation == OP_START &&
							    32'(task_index) <= 32'(ring_last)) begin
								running_q <= IW'(task_index);
							end
						end
					end
				end
				S_PREP: begin
					cand_ready_q <= (rd_entry.state == ST_READY);
					state_q      <= S_WALK;
				end
				S_WALK: begin
					if (take_cand) begin
						cand_q       <= t_q;
						cand_ready_q <= 1'b1;
					end else if (t_q == cand_q && made_ready) begin
						// initial candidate turned ready during this walk
						cand_ready_q <= 1'b1;
					end
					t_q    <= t_next;
					left_q <= left_q - IW'(1);
					if (left_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						running_q <= cand_q;
						state_q   <= S_IDLE;
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mask_q <= semaphore_free_mask;
		end
		if (state_q == S_PREP) begin
			cand_prio_q <= rd_entry.prio;
		end else if (state_q == S_WALK && take_cand) begin
			cand_prio_q <= rd_entry.prio;
		end
		if (in_acc && operation != OP_TICK) begin
			if (operation == OP_START && 32'(task_index) <= 32'(ring_last)) begin
				out_task_q <= task_index;
				out_sw_q   <= (IW'(task_index) != running_q);
			end else begin
				out_task_q <= 3'(running_q);
				out_sw_q   <= 1'b0;
			end
		end else if (state_q == S_FIN && slot_free) begin
			out_task_q <= 3'(cand_q);
			out_sw_q   <= (cand_q != running_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_sw_q, out_task_q};

endmodule

>>> rtl/tpts_checker.sv
// Port-level checks for the task scheduler, bound to the top level.
// Depends on tpts_pkg and tick_priority_task_scheduler.
`timescale 1ns / 1ps

module tpts_checker import tpts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// write, start and unused beats give their result on the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != OP_TICK |=> m_tvalid)
		else $error("no result after a single-cycle beat");

	// a tick keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready && !m_tvalid)
		else $error("block not busy after a tick");

	// a write never changes the current task
	a_write_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_WRITE |=> !m_tdata[3])
		else $error("switch flagged on a write");

	// input only taken while the result slot is free or draining
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input ready while result slot is blocked");

endmodule

bind tick_priority_task_scheduler tpts_checker u_tpts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/tick_priority_task_scheduler_tb.sv
// Self-checking testbench for tick_priority_task_scheduler.
// Drives item beats, checks every result beat against a task-table predictor.
// Depends on tpts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tick_priority_task_scheduler_tb;
	import tpts_pkg::*;

	localparam int NUM_TASKS = 8;
	// unused item kind; the block must answer it without touching state
	localparam logic [1:0] OP_NONE = 2'd3;
	// cycles with no beat on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// extra wait at the end of the run, once every expected result has come back
	localparam int TAIL_CYCLES = NUM_TASKS + 4;

	// one input item, field by field
	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  idx;
		logic [1:0]  st;
		logic [31:0] dly;
		logic [7:0]  prio;
		logic [7:0]  mask;
	} sched_item_t;

	// one result beat
	typedef struct packed {
		logic [2:0] cur;
		logic       sw;
	} sched_res_t;

	// directed row: optional ring size change before the item, optional fixed result
	typedef struct packed {
		logic        set_cnt;
		logic [3:0]  cnt;
		sched_item_t it;
		logic        fixed;
		sched_res_t  res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        task_count_we = 1'b0;
	logic [3:0]  task_count_wdata = 4'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	// predictor state: mirrors the block's task table and ring size
	logic [3:0]  ring_cnt = 4'd1;
	logic [2:0]  run_task = 3'd0;
	logic [1:0]  tsk_state [NUM_TASKS];
	logic [31:0] tsk_delay [NUM_TASKS];
	logic [7:0]  tsk_prio  [NUM_TASKS];

	sched_res_t  sched_q [$];     // expected results, oldest first
	int          err_count = 0;
	int          idle_cycles = 0;
	bit          no_idle = 1'b0;  // set for phases that run both sides flat out
	int          rdy_hold = 0;

	tick_priority_task_scheduler #(
		.NUM_TASKS(NUM_TASKS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.task_count_we    (task_count_we),
		.task_count_wdata (task_count_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	always #5 clk = ~clk;

	// Directed rows. Fixed results only where obvious: right after reset every
	// entry is inactive and the ring has one task, so nothing can move.
	dir_row_t dir_tab [0:24] = '{
		// reset state: tick, start outside ring, unused kind with every bit set
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b1, '{3'd0, 1'b0}},
		'{1'b0, 4'd0,  '{OP_START, 3'd1, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b1, '{3'd0, 1'b0}},
		'{1'b0, 4'd0,  '{OP_NONE,  3'd7, ST_WAITING,  32'hFFFFFFFF, 8'hFF,  8'hFF}, 1'b1, '{3'd0, 1'b0}},
		// full ring: mix of ready, delayed and semaphore-waiting entries
		'{1'b1, 4'd8,  '{OP_WRITE, 3'd7, ST_READY,    32'd0,        8'd255, 8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_WRITE, 3'd3, ST_DELAYED,  32'd2,        8'd10,  8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_WRITE, 3'd5, ST_WAITING,  32'hFFFFFFFF, 8'd255, 8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd7, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		// free bit of task 5 releases it; equal priority 255 ties with task 7
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h20}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'hFF}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_WRITE, 3'd0, ST_READY,    32'hFFFFFFFF, 8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b1, '{3'd0, 1'b0}},
		// ring size above the table acts as the full table
		'{1'b1, 4'd15, '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd7, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		// ring size 0 acts as 1; current task 7 now lies outside the ring
		'{1'b1, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		// small ring: timeouts of one tick run out
		'{1'b1, 4'd3,  '{OP_WRITE, 3'd2, ST_WAITING,  32'd1,        8'd5,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_WRITE, 3'd1, ST_DELAYED,  32'd1,        8'd5,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_WRITE, 3'd6, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd2, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_TICK,  3'd0, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0},
		'{1'b0, 4'd0,  '{OP_START, 3'd5, ST_INACTIVE, 32'd0,        8'd0,   8'h00}, 1'b0, '0}
	};

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	function automatic int ring_succ(input int i, input int n);
		return (i + 1 < n) ? i + 1 : 0;
	endfunction

	// delayed/waiting entry: count down, ready once the count is zero
	function automatic void count_down(input int t);
		if (tsk_delay[t] != 32'd0)
			tsk_delay[t] = tsk_delay[t] - 32'd1;
		if (tsk_delay[t] == 32'd0)
			tsk_state[t] = ST_READY;
	endfunction

	function automatic sched_res_t sched_predict(input sched_item_t it);
		sched_res_t r;
		logic [2:0] prev;
		int n;
		int t;
		int cand;
		int k;
		prev = run_task;
		n = (ring_cnt == 4'd0) ? 1 : (ring_cnt > NUM_TASKS) ? NUM_TASKS : int'(ring_cnt);
		case (it.op)
			OP_TICK: begin
				// walk starts at the current task, or at 0 if it fell out of the ring
				t = (int'(run_task) < n) ? int'(run_task) : 0;
				cand = ring_succ(t, n);
				for (k = 0; k < n; k++) begin
					case (tsk_state[t])
						ST_DELAYED: count_down(t);
						ST_WAITING: begin
							if (it.mask[t])
								tsk_state[t] = ST_READY;
							count_down(t);
						end
						ST_READY: begin
							// candidate state and priority are read as they stand now
							if (tsk_state[cand] != ST_READY)
								cand = t;
							if (tsk_prio[t] >= tsk_prio[cand])
								cand = t;
						end
						default: ;
					endcase
					t = ring_succ(t, n);
				end
				run_task = cand[2:0];
			end
			OP_WRITE: begin
				tsk_state[it.idx] = it.st;
				tsk_delay[it.idx] = it.dly;
				tsk_prio[it.idx]  = it.prio;
			end
			OP_START: begin
				if (int'(it.idx) < n)
					run_task = it.idx;
			end
			default: ;
		endcase
		r.cur = run_task;
		r.sw  = (run_task != prev);
		return r;
	endfunction

	initial begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			tsk_state[i] = ST_INACTIVE;
			tsk_delay[i] = 32'd0;
			tsk_prio[i]  = 8'd0;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random item. Writes carry mostly short delays and close priorities so
	// that tasks actually come ready and tie; fields an item ignores get junk.
	function automatic sched_item_t gen_item();
		sched_item_t it;
		int r;
		it.idx  = $urandom_range(0, 7);
		it.st   = $urandom_range(0, 3);
		it.dly  = $urandom();
		it.prio = $urandom_range(0, 255);
		it.mask = $urandom_range(0, 255);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			it.op = OP_WRITE;
			r = $urandom_range(0, 9);
			if (r < 7)
				it.dly = $urandom_range(0, 4);
			else if (r < 9)
				it.dly = $urandom_range(0, 40);
			if ($urandom_range(0, 1))
				it.prio = $urandom_range(0, 3);
		end else if (r < 80) begin
			it.op = OP_TICK;
		end else if (r < 95) begin
			it.op = OP_START;
		end else begin
			it.op = OP_NONE;
		end
		return it;
	endfunction

	// One input beat. Valid stays high across back-to-back beats; the
	// expectation is queued at the accepting edge.
	task automatic send(input sched_item_t it, input logic fixed, input sched_res_t res);
		int gap;
		sched_res_t pred;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, it.mask, it.prio, it.dly, it.st, it.idx};
		s_tuser  <= it.op;
		do @(posedge clk); while (!s_tready);
		pred = sched_predict(it);
		sched_q.push_back(fixed ? res : pred);
	endtask

	// sender holds off until every expected result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sched_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// ring size is only changed with the block idle
	task automatic set_count(input logic [3:0] v);
		wait_drained();
		task_count_we    <= 1'b1;
		task_count_wdata <= v;
		@(posedge clk);
		task_count_we <= 1'b0;
		ring_cnt = v;
	endtask

	task automatic flag_err(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------------
	// Result side: random back-pressure, then compare against the queue
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold--;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 2) != 0);
			rdy_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (sched_q.size() == 0) begin
				flag_err($sformatf("result beat with nothing expected, tdata=%h", m_tdata));
			end else begin
				want = sched_q.pop_front();
				if (m_tdata[2:0] != want.cur)
					flag_err($sformatf("current_task exp %0d got %0d", want.cur, m_tdata[2:0]));
				if (m_tdata[3] != want.sw)
					flag_err($sformatf("switched exp %0d got %0d", want.sw, m_tdata[3]));
			end
		end
	end

	// hang detector: counts cycles without a beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		logic [3:0] cnt_v;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int j = 0; j < 25; j++) begin
			if (dir_tab[j].set_cnt)
				set_count(dir_tab[j].cnt);
			send(dir_tab[j].it, dir_tab[j].fixed, dir_tab[j].res);
		end

		// random phases, each with its own ring size; extremes included
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: cnt_v = 4'd8;
				1: cnt_v = 4'd1;
				2: cnt_v = 4'd0;
				3: cnt_v = 4'd15;
				4: cnt_v = 4'd3;
				5: cnt_v = 4'd5;
				6: cnt_v = 4'd8;
				7: cnt_v = 4'd2;
				default: cnt_v = $urandom_range(0, 15);
			endcase
			set_count(cnt_v);
			no_idle = (ph == 2 || ph == 6);
			for (int j = 0; j < 45; j++) begin
				if ($urandom_range(0, 39) == 0)
					wait_drained();
				send(gen_item(), 1'b0, '0);
			end
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && sched_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
